// File: rtl/tfpd_pkg.sv
// ----------------------------------------------------------------------------
// tfpd_pkg
// Shared types, codes and defaults for the ranging frame plane deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfpd_pkg;

  localparam int MAX_ZONES_DEF      = 4096;
  localparam int STATUS_BYTES_DEF   = 100;
  localparam int COUNTER_OFFSET_DEF = 0;
  localparam int TEMP_OFFSET_DEF    = 4;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS     = 2'd0;
  localparam logic [1:0] REG_OUTPUT_ROWS = 2'd1;
  localparam logic [1:0] REG_SENT_ROWS   = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET  = 2'd3;

  // parser operation codes
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_DEPTH   = 3'd1;
  localparam logic [2:0] OP_AMP     = 3'd2;
  localparam logic [2:0] OP_AMBIENT = 3'd3;
  localparam logic [2:0] OP_FRAME   = 3'd4;

  // result kinds
  localparam logic KIND_ZONE  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [11:0] zone_index;
    logic [14:0] range_mm;
    logic        target_valid;
    logic [15:0] amplitude;
    logic [15:0] ambient_level;
    logic [31:0] sensor_frame_count;
    logic [15:0] temperature;
    logic [31:0] sequence_res;
    logic        geometry_error;
    logic        frame_last;
  } out_t;

  // frame layout derived from the configuration registers
  typedef struct packed {
    logic [14:0] plane;    // 2 * zones
    logic [15:0] plane2;   // 4 * zones
    logic [16:0] plane3;   // 6 * zones
    logic [16:0] sbase;    // first status byte
    logic [16:0] total;    // frame length
    logic [12:0] lo_lim;   // row_offset * columns
    logic [14:0] hi_lim;   // (row_offset + output_rows) * columns
    logic        bad;
  } geo_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [13:0] zone;
    logic [15:0] word;
    logic [31:0] counter;
    logic [15:0] temp;
    logic [31:0] seq;
    logic        bad;
  } op_t;

endpackage

`default_nettype wire

// File: rtl/tfpd_cfg.sv
// ----------------------------------------------------------------------------
// tfpd_cfg
// Configuration registers and two-stage computation of the frame layout.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpd_cfg #(
  parameter int MAX_ZONES    = tfpd_pkg::MAX_ZONES_DEF,
  parameter int STATUS_BYTES = tfpd_pkg::STATUS_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           write,
  input  wire logic [1:0]     index,
  input  wire logic [6:0]     data,
  output tfpd_pkg::geo_t      geo,
  output logic                busy
);

  localparam logic [13:0] ZONE_LIMIT = 14'(MAX_ZONES);
  localparam logic [16:0] STATUS_LEN = 17'(STATUS_BYTES);

  logic [6:0]  columns;
  logic [6:0]  output_rows;
  logic [6:0]  sent_rows;
  logic [5:0]  row_offset;
  logic [1:0]  hold;

  logic [13:0] zones;
  logic [12:0] lo_lim;
  logic [14:0] hi_lim;
  logic        bad_cfg;
  logic [7:0]  span;

  tfpd_pkg::geo_t geo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns     <= 7'd4;
      output_rows <= 7'd4;
      sent_rows   <= 7'd4;
      row_offset  <= 6'd0;
    end else if (write) begin
      case (index)
        tfpd_pkg::REG_COLUMNS:     columns     <= data;
        tfpd_pkg::REG_OUTPUT_ROWS: output_rows <= data;
        tfpd_pkg::REG_SENT_ROWS:   sent_rows   <= data;
        tfpd_pkg::REG_ROW_OFFSET:  row_offset  <= data[5:0];
        default: ;
      endcase
    end
  end

  // keep bytes out until the layout has caught up with a write
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 2'd2;
    end else if (write) begin
      hold <= 2'd2;
    end else if (hold != 2'd0) begin
      hold <= hold - 2'd1;
    end
  end

  assign busy = (hold != 2'd0);
  assign span = {2'b00, row_offset} + {1'b0, output_rows};

  always_ff @(posedge clk) begin
    zones   <= {7'd0, columns} * {7'd0, sent_rows};
    lo_lim  <= {7'd0, row_offset} * {6'd0, columns};
    hi_lim  <= {7'd0, span} * {8'd0, columns};
    bad_cfg <= (columns == 7'd0) || (output_rows == 7'd0) || (sent_rows == 7'd0) ||
               (span > {1'b0, sent_rows});
  end

  always_comb begin
    geo_next.plane  = {zones, 1'b0};
    geo_next.plane2 = {zones, 2'b00};
    geo_next.plane3 = {1'b0, geo_next.plane2} + {2'b00, geo_next.plane};
    geo_next.sbase  = geo_next.plane3 + {4'd0, zones[13:1]};
    geo_next.total  = geo_next.sbase + STATUS_LEN;
    geo_next.lo_lim = lo_lim;
    geo_next.hi_lim = hi_lim;
    geo_next.bad    = bad_cfg || (zones > ZONE_LIMIT);
  end

  always_ff @(posedge clk) begin
    geo <= geo_next;
  end

endmodule

`default_nettype wire

// File: rtl/tfpd_parser.sv
// ----------------------------------------------------------------------------
// tfpd_parser
// Tracks the byte position, pairs bytes into words, assembles the status line
// and issues one operation per word or frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpd_parser #(
  parameter int STATUS_BYTES   = tfpd_pkg::STATUS_BYTES_DEF,
  parameter int COUNTER_OFFSET = tfpd_pkg::COUNTER_OFFSET_DEF,
  parameter int TEMP_OFFSET    = tfpd_pkg::TEMP_OFFSET_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire tfpd_pkg::in_t  in_data,
  input  wire tfpd_pkg::geo_t geo,
  input  wire logic           op_take,
  output logic                op_valid,
  output tfpd_pkg::op_t       op
);

  localparam logic [8:0] CNT_OFS  = 9'(COUNTER_OFFSET);
  localparam logic [8:0] TMP_OFS  = 9'(TEMP_OFFSET);
  localparam logic [8:0] LAST_IDX = 9'(STATUS_BYTES - 1);

  logic [15:0] pos;
  logic [7:0]  low_hold;
  logic [31:0] counter;
  logic [15:0] temp;
  logic [31:0] seq;

  logic [15:0] pos_next;
  logic [7:0]  low_hold_next;
  logic [31:0] counter_next;
  logic [15:0] temp_next;
  logic [31:0] seq_next;
  tfpd_pkg::op_t op_next;

  logic [15:0] p;
  logic [16:0] p17;
  logic        active;
  logic        in_planes;
  logic        in_status;
  logic [1:0]  plane_sel;
  logic [15:0] plane_base;
  logic [15:0] off;
  logic [16:0] sidx;
  logic [8:0]  i9;
  logic [8:0]  cnt_lane;
  logic [8:0]  tmp_lane;
  logic        cnt_hit;
  logic        tmp_hit;

  always_comb begin
    p         = in_data.frame_start ? 16'd0 : pos;
    p17       = {1'b0, p};
    active    = (p17 < geo.total) && (p != 16'hFFFF);
    in_planes = p17 < geo.plane3;
    in_status = p17 >= geo.sbase;

    if (p17 < {2'b00, geo.plane}) begin
      plane_sel  = 2'd0;
      plane_base = 16'd0;
    end else if (p17 < {1'b0, geo.plane2}) begin
      plane_sel  = 2'd1;
      plane_base = {1'b0, geo.plane};
    end else begin
      plane_sel  = 2'd2;
      plane_base = geo.plane2;
    end
    off = p - plane_base;

    sidx     = p17 - geo.sbase;
    i9       = sidx[8:0];
    cnt_lane = i9 - CNT_OFS;
    tmp_lane = i9 - TMP_OFS;
    cnt_hit  = (i9 >= CNT_OFS) && (cnt_lane < 9'd4);
    tmp_hit  = (i9 >= TMP_OFS) && (tmp_lane < 9'd2);

    low_hold_next = low_hold;
    counter_next  = counter;
    temp_next     = temp;
    seq_next      = seq;
    op_next.kind    = tfpd_pkg::OP_NONE;
    op_next.zone    = off[14:1];
    op_next.word    = {in_data.frame_byte, low_hold};
    op_next.counter = 32'd0;
    op_next.temp    = 16'd0;
    op_next.seq     = 32'd0;
    op_next.bad     = geo.bad;

    if (active) begin
      if (in_planes) begin
        if (!off[0]) begin
          low_hold_next = in_data.frame_byte;
        end else begin
          case (plane_sel)
            2'd0:    op_next.kind = tfpd_pkg::OP_DEPTH;
            2'd1:    op_next.kind = tfpd_pkg::OP_AMP;
            default: op_next.kind = tfpd_pkg::OP_AMBIENT;
          endcase
        end
      end else if (in_status) begin
        if (cnt_hit) begin
          counter_next[{cnt_lane[1:0], 3'b000} +: 8] = in_data.frame_byte;
        end
        if (tmp_hit) begin
          temp_next[{tmp_lane[0], 3'b000} +: 8] = in_data.frame_byte;
        end
        if (i9 == LAST_IDX) begin
          seq_next        = seq + 32'd1;
          op_next.kind    = tfpd_pkg::OP_FRAME;
          op_next.counter = counter_next;
          op_next.temp    = temp_next;
          op_next.seq     = seq_next;
        end
      end
    end

    pos_next = active ? p + 16'd1 : p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 16'd0;
      low_hold <= 8'd0;
      counter  <= 32'd0;
      temp     <= 16'd0;
      seq      <= 32'd0;
      op_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos      <= pos_next;
        low_hold <= low_hold_next;
        counter  <= counter_next;
        temp     <= temp_next;
        seq      <= seq_next;
        op_valid <= (op_next.kind != tfpd_pkg::OP_NONE);
      end else if (op_take) begin
        op_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tfpd_store.sv
// ----------------------------------------------------------------------------
// tfpd_store
// Depth and amplitude zone memories, crop window test and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpd_store #(
  parameter int MAX_ZONES = tfpd_pkg::MAX_ZONES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           op_valid,
  input  wire tfpd_pkg::op_t  op,
  input  wire tfpd_pkg::geo_t geo,
  input  wire logic           res_take,
  output logic                op_take,
  output logic                res_valid,
  output tfpd_pkg::out_t      res
);

  localparam int          AW         = $clog2(MAX_ZONES);
  localparam logic [13:0] ZONE_LIMIT = 14'(MAX_ZONES);

  logic [15:0] depth_mem [0:MAX_ZONES-1];
  logic [15:0] amp_mem   [0:MAX_ZONES-1];
  logic [15:0] depth_q;
  logic [15:0] amp_q;

  logic        b_kind;
  logic [11:0] b_zone;
  logic [15:0] b_ambient;
  logic [31:0] b_counter;
  logic [15:0] b_temp;
  logic [31:0] b_seq;
  logic        b_bad;

  logic [AW-1:0] addr;
  logic          in_range;
  logic          in_window;
  logic          emit_zone;
  logic          emit_frame;
  logic [14:0]   zone_rel;

  assign addr       = op.zone[AW-1:0];
  assign in_range   = op.zone < ZONE_LIMIT;
  assign in_window  = ({1'b0, op.zone} >= {2'b00, geo.lo_lim}) &&
                      ({1'b0, op.zone} < geo.hi_lim);
  assign emit_zone  = (op.kind == tfpd_pkg::OP_AMBIENT) && in_range && in_window;
  assign emit_frame = (op.kind == tfpd_pkg::OP_FRAME);
  assign zone_rel   = {1'b0, op.zone} - {2'b00, geo.lo_lim};
  assign op_take    = op_valid && (!res_valid || res_take);

  always_ff @(posedge clk) begin
    if (op_take && in_range && (op.kind == tfpd_pkg::OP_DEPTH)) begin
      depth_mem[addr] <= op.word;
    end
    if (op_take && emit_zone) begin
      depth_q <= depth_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && in_range && (op.kind == tfpd_pkg::OP_AMP)) begin
      amp_mem[addr] <= op.word;
    end
    if (op_take && emit_zone) begin
      amp_q <= amp_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op_take) begin
      res_valid <= emit_zone || emit_frame;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      b_kind    <= emit_frame ? tfpd_pkg::KIND_FRAME : tfpd_pkg::KIND_ZONE;
      b_zone    <= zone_rel[11:0];
      b_ambient <= op.word;
      b_counter <= op.counter;
      b_temp    <= op.temp;
      b_seq     <= op.seq;
      b_bad     <= op.bad;
    end
  end

  always_comb begin
    res.item_kind = b_kind;
    if (b_kind == tfpd_pkg::KIND_ZONE) begin
      res.zone_index         = b_zone;
      res.range_mm           = depth_q[14:0];
      res.target_valid       = depth_q[15];
      res.amplitude          = amp_q;
      res.ambient_level      = b_ambient;
      res.sensor_frame_count = 32'd0;
      res.temperature        = 16'd0;
      res.sequence_res       = 32'd0;
      res.geometry_error     = 1'b0;
      res.frame_last         = 1'b0;
    end else begin
      res.zone_index         = 12'd0;
      res.range_mm           = 15'd0;
      res.target_valid       = 1'b0;
      res.amplitude          = 16'd0;
      res.ambient_level      = 16'd0;
      res.sensor_frame_count = b_counter;
      res.temperature        = b_temp;
      res.sequence_res       = b_seq;
      res.geometry_error     = b_bad;
      res.frame_last         = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tof_frame_plane_deframer.sv
// ----------------------------------------------------------------------------
// tof_frame_plane_deframer
// Splits a raw ranging frame into per-zone depth/amplitude/ambient results
// and an end of frame status result.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   tfpd_pkg::in_t  (one frame byte)
//   out      output     out_valid/out_stall tfpd_pkg::out_t (zone or frame)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte a cycle while in_stall is low; a result leaves through the parser
// register, memory read stage and output register after its byte is taken.
// rst clears control state and holds bytes off after it until the layout has caught up.
// A config write holds bytes off while the layout recomputes; the zone stores
// are not cleared and are read only after a write.
// out_stall backs up through the pipeline only when every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_frame_plane_deframer #(
  parameter int MAX_ZONES      = tfpd_pkg::MAX_ZONES_DEF,
  parameter int STATUS_BYTES   = tfpd_pkg::STATUS_BYTES_DEF,
  parameter int COUNTER_OFFSET = tfpd_pkg::COUNTER_OFFSET_DEF,
  parameter int TEMP_OFFSET    = tfpd_pkg::TEMP_OFFSET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tfpd_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tfpd_pkg::out_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [6:0]    cfg_data
);

  tfpd_pkg::geo_t geo;
  tfpd_pkg::op_t  op;
  tfpd_pkg::out_t res;

  logic busy;
  logic accept;
  logic op_valid;
  logic op_take;
  logic res_valid;
  logic res_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = cfg_valid || busy || (op_valid && !op_take);
  assign accept    = in_valid && !in_stall;
  assign res_take  = !out_valid || !out_stall;

  tfpd_cfg #(
    .MAX_ZONES    (MAX_ZONES),
    .STATUS_BYTES (STATUS_BYTES)
  ) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .write (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .geo   (geo),
    .busy  (busy)
  );

  tfpd_parser #(
    .STATUS_BYTES   (STATUS_BYTES),
    .COUNTER_OFFSET (COUNTER_OFFSET),
    .TEMP_OFFSET    (TEMP_OFFSET)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .geo      (geo),
    .op_take  (op_take),
    .op_valid (op_valid),
    .op       (op)
  );

  tfpd_store #(
    .MAX_ZONES (MAX_ZONES)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .geo       (geo),
    .res_take  (res_take),
    .op_take   (op_take),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("byte accepted right after reset");

  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> in_stall)
    else $error("byte accepted before layout update");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.frame_last == out_data.item_kind))
    else $error("frame_last does not match item kind");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.item_kind == tfpd_pkg::KIND_ZONE) |->
      (out_data.sequence_res == 32'd0 && !out_data.geometry_error))
    else $error("zone word carries frame fields");
`endif

endmodule

`default_nettype wire
